/* sv/rv32i_core_mem_sequencer_assert.svh */
// Assertion macros used by the core top-level RTL file.
`ifndef RV32I_CORE_MEM_SEQUENCER_ASSERT_SVH
`define RV32I_CORE_MEM_SEQUENCER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define RCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define RCS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");

`endif

/* sv/rcs_pkg.sv */
package rcs_pkg;

  localparam logic [32:0] MemBytesDefault = 33'd65536;

  typedef enum logic [1:0] {
    PH_FETCH = 2'd0,
    PH_LOAD  = 2'd1,
    PH_STORE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EXC_BREAK     = 2'd0,
    EXC_MISALIGN  = 2'd1,
    EXC_ILLEGAL   = 2'd2
  } exc_e;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_FENCE  = 7'h0F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [31:0] InstrEcall  = 32'h0000_0073;
  localparam logic [31:0] InstrEbreak = 32'h0010_0073;

  localparam logic [4:0] RegSp = 5'd2;
  localparam logic [4:0] RegA0 = 5'd10;
  localparam logic [4:0] RegA1 = 5'd11;

  typedef logic [13:0] waddr_t;

  // One result item.
  typedef struct packed {
    waddr_t      mem_word_addr;
    logic        write_enable;
    logic [31:0] write_data;
    logic        exception_valid;
    logic [1:0]  exception_code;
    logic        ecall_valid;
    logic [31:0] ecall_arg0;
    logic [31:0] ecall_arg1;
    logic        is_last;
  } result_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] read_data;
  } cmd_t;

  // Outcome of one step: up to two results and the state updates.
  typedef struct packed {
    logic        n_res;      // 0: one result, 1: two results
    logic        any_res;
    result_t     res0;
    result_t     res1;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [31:0] pc_next;
    phase_e      phase_next;
    logic [31:0] pend_next;
    logic        halt_next;
  } step_t;

  function automatic logic [31:0] sext12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic result_t mk_res(input logic [31:0] baddr, input logic we,
                                     input logic [31:0] wd, input logic last);
    result_t r;
    r = '0;
    r.mem_word_addr = baddr[15:2];
    r.write_enable  = we;
    r.write_data    = wd;
    r.is_last       = last;
    return r;
  endfunction

  function automatic result_t mk_exc(input exc_e code);
    result_t r;
    r = '0;
    r.exception_valid = 1'b1;
    r.exception_code  = code;
    r.is_last         = 1'b1;
    return r;
  endfunction

endpackage

/* sv/rcs_stream_if.sv */
interface rcs_stream_if #(
  parameter int unsigned Width = 1
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/rcs_exec.sv */
module rcs_exec import rcs_pkg::*; (
  input  cmd_t        cmd_i,
  input  logic [31:0] stack_init_i,
  input  logic [31:0] pc_i,
  input  phase_e      phase_i,
  input  logic [31:0] pend_i,
  input  logic        halt_i,
  input  logic [31:0] rs1_val_i,
  input  logic [31:0] rs2_val_i,
  input  logic [31:0] a0_val_i,
  input  logic [31:0] a1_val_i,
  output logic [4:0]  rs1_o,
  output logic [4:0]  rs2_o,
  output step_t       step_o
);

  logic [31:0] w, data, a, b, imm_i, imm_s, imm_b, imm_j, addr, nxt, pc4, alu_b, alu_r;
  logic [31:0] v, m, sh_v;
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd, shamt, off;
  logic        cond, alt, lts, ltu;

  assign data = cmd_i.read_data;
  assign w    = (phase_i == PH_FETCH) ? data : pend_i;
  assign op   = w[6:0];
  assign rd   = w[11:7];
  assign f3   = w[14:12];
  assign f7   = w[31:25];
  assign rs1_o = w[19:15];
  assign rs2_o = w[24:20];
  assign a    = rs1_val_i;
  assign b    = rs2_val_i;
  assign imm_i = sext12(w[31:20]);
  assign imm_s = sext12({w[31:25], w[11:7]});
  assign imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
  assign addr = a + ((op == OP_STORE) ? imm_s : imm_i);
  assign pc4  = pc_i + 32'd4;
  assign lts  = $signed(a) < $signed(alu_b);
  assign ltu  = a < alu_b;
  assign alu_b = (op == OP_REG || op == OP_BRANCH) ? b : imm_i;
  assign shamt = alu_b[4:0];
  assign alt   = (op == OP_REG) ? (f7 == 7'h20) : (f3 == 3'd5 && f7 == 7'h20);

  // ALU
  always_comb begin
    case (f3)
      3'd0:    alu_r = (alt && op == OP_REG) ? a - alu_b : a + alu_b;
      3'd1:    alu_r = a << shamt;
      3'd2:    alu_r = {31'd0, lts};
      3'd3:    alu_r = {31'd0, ltu};
      3'd4:    alu_r = a ^ alu_b;
      3'd5:    alu_r = alt ? 32'($signed(a) >>> shamt) : a >> shamt;
      3'd6:    alu_r = a | alu_b;
      default: alu_r = a & alu_b;
    endcase
  end

  // Branch condition
  always_comb begin
    case (f3)
      3'd0:    cond = (a == b);
      3'd1:    cond = (a != b);
      3'd4:    cond = lts;
      3'd5:    cond = !lts;
      3'd6:    cond = ltu;
      default: cond = !ltu;
    endcase
  end

  // Byte lane shift for load extract and store merge
  assign off  = (f3[1:0] == 2'd0) ? {addr[1:0], 3'd0} : {addr[1], 4'd0};
  assign sh_v = data >> off;
  assign m    = (f3[1:0] == 2'd0) ? 32'hFF : 32'hFFFF;

  always_comb begin
    case (f3)
      3'd0:    v = {{24{sh_v[7]}}, sh_v[7:0]};
      3'd1:    v = {{16{sh_v[15]}}, sh_v[15:0]};
      3'd4:    v = {24'd0, sh_v[7:0]};
      3'd5:    v = {16'd0, sh_v[15:0]};
      default: v = data;
    endcase
  end

  // Step decision
  always_comb begin
    step_t s;
    logic  ill, jmp;
    s = '0;
    s.any_res    = 1'b1;
    s.pc_next    = pc_i;
    s.phase_next = PH_FETCH;
    s.pend_next  = pend_i;
    s.halt_next  = halt_i;
    s.rf_waddr   = rd;
    ill = 1'b0;
    jmp = 1'b0;
    nxt = pc4;
    if (!cmd_i.cmd) begin
      s.pc_next   = '0;
      s.pend_next = '0;
      s.halt_next = 1'b0;
      s.rf_we     = 1'b1;
      s.rf_waddr  = RegSp;
      s.rf_wdata  = stack_init_i;
      s.res0      = mk_res(32'd0, 1'b0, 32'd0, 1'b1);
    end else if (halt_i) begin
      s.any_res = 1'b0;
    end else if (phase_i == PH_LOAD) begin
      s.rf_we    = 1'b1;
      s.rf_wdata = v;
      s.pc_next  = pc4;
      s.res0     = mk_res(pc4, 1'b0, 32'd0, 1'b1);
    end else if (phase_i == PH_STORE) begin
      s.pc_next = pc4;
      s.n_res   = 1'b1;
      s.res0    = mk_res(addr, 1'b1, (data & ~(m << off)) | ((b & m) << off), 1'b0);
      s.res1    = mk_res(pc4, 1'b0, 32'd0, 1'b1);
    end else begin
      unique case (op)
        OP_LUI:    begin s.rf_we = 1'b1; s.rf_wdata = {w[31:12], 12'd0}; jmp = 1'b1; end
        OP_AUIPC:  begin s.rf_we = 1'b1; s.rf_wdata = pc_i + {w[31:12], 12'd0}; jmp = 1'b1; end
        OP_JAL:    begin s.rf_we = 1'b1; s.rf_wdata = pc4; nxt = pc_i + imm_j; jmp = 1'b1; end
        OP_JALR: begin
          if (f3 != 3'd0) ill = 1'b1;
          else begin
            s.rf_we = 1'b1; s.rf_wdata = pc4; nxt = (a + imm_i) & ~32'd1; jmp = 1'b1;
          end
        end
        OP_BRANCH: begin
          if (f3 == 3'd2 || f3 == 3'd3) ill = 1'b1;
          else begin
            if (cond) nxt = pc_i + imm_b;
            jmp = 1'b1;
          end
        end
        OP_LOAD: begin
          if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) ill = 1'b1;
          else if ((f3 == 3'd2 && addr[1:0] != 2'd0) ||
                   ((f3 == 3'd1 || f3 == 3'd5) && addr[0])) begin
            s.halt_next = 1'b1;
            s.res0      = mk_exc(EXC_MISALIGN);
          end else begin
            s.pend_next  = w;
            s.phase_next = PH_LOAD;
            s.res0       = mk_res(addr, 1'b0, 32'd0, 1'b1);
          end
        end
        OP_STORE: begin
          if (f3 > 3'd2) ill = 1'b1;
          else if ((f3 == 3'd2 && addr[1:0] != 2'd0) || (f3 == 3'd1 && addr[0])) begin
            s.halt_next = 1'b1;
            s.res0      = mk_exc(EXC_MISALIGN);
          end else if (f3 == 3'd2) begin
            s.pc_next = pc4;
            s.n_res   = 1'b1;
            s.res0    = mk_res(addr, 1'b1, b, 1'b0);
            s.res1    = mk_res(pc4, 1'b0, 32'd0, 1'b1);
          end else begin
            s.pend_next  = w;
            s.phase_next = PH_STORE;
            s.res0       = mk_res(addr, 1'b0, 32'd0, 1'b1);
          end
        end
        OP_IMM: begin
          if ((f3 == 3'd1 && f7 != 7'd0) ||
              (f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20)) ill = 1'b1;
          else begin s.rf_we = 1'b1; s.rf_wdata = alu_r; jmp = 1'b1; end
        end
        OP_REG: begin
          if (f7 != 7'd0 && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) ill = 1'b1;
          else begin s.rf_we = 1'b1; s.rf_wdata = alu_r; jmp = 1'b1; end
        end
        OP_FENCE: begin
          if (f3 != 3'd0) ill = 1'b1;
          else jmp = 1'b1;
        end
        OP_SYSTEM: begin
          if (w == InstrEbreak) begin
            s.halt_next = 1'b1;
            s.res0      = mk_exc(EXC_BREAK);
          end else if (w != InstrEcall) ill = 1'b1;
          else begin
            jmp = 1'b1;
            s.res0.ecall_valid = 1'b1;
          end
        end
        default: ill = 1'b1;
      endcase
      if (ill) begin
        s.rf_we     = 1'b0;
        s.halt_next = 1'b1;
        s.res0      = mk_exc(EXC_ILLEGAL);
      end else if (jmp) begin
        s.pc_next = nxt;
        if (nxt[1:0] != 2'd0) begin
          s.halt_next = 1'b1;
          s.res0      = mk_exc(EXC_MISALIGN);
        end else begin
          s.res0.mem_word_addr = nxt[15:2];
          s.res0.is_last       = 1'b1;
          if (s.res0.ecall_valid) begin
            s.res0.ecall_arg0 = a0_val_i;
            s.res0.ecall_arg1 = a1_val_i;
          end
        end
      end
    end
    if (s.rf_waddr == 5'd0) s.rf_we = 1'b0;
    step_o = s;
  end

endmodule

/* sv/rcs_out_queue.sv */
module rcs_out_queue import rcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  logic    two_i,
  input  result_t res0_i,
  input  result_t res1_i,
  output logic    can_push_o,
  rcs_stream_if.source out_o
);

  // Two-entry holding buffer; a new push is allowed once at most one entry remains
  // and it will drain, or the buffer is empty.
  result_t    buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop        = out_o.valid && out_o.ready;
  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data = buf_q[0];
  assign can_push_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);

  always_comb begin
    cnt_d = cnt_q - {1'b0, pop};
    if (push_i) cnt_d = cnt_d + (two_i ? 2'd2 : 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  // Load new results (any remaining entry drains in the same cycle), else advance
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[0] <= res0_i;
      buf_q[1] <= res1_i;
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
    end
  end

endmodule

/* sv/rv32i_core_mem_sequencer.sv */
// RV32I core sequenced by memory responses. Every accepted transfer (start
// command or read response) is decoded and executed combinationally and its one
// or two memory requests are placed in a two-entry output buffer, so a new
// transfer is taken every cycle while the sink keeps up; a word store or
// byte/halfword store completion gives two results, which hold the input until
// one drains. The register file is flip-flops read at four ports (rs1, rs2, a0, a1).
module rv32i_core_mem_sequencer import rcs_pkg::*; #(
  parameter logic [32:0] MemBytes = MemBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  rcs_stream_if.sink   in_i,
  rcs_stream_if.source out_o
);

`include "rv32i_core_mem_sequencer_assert.svh"

  logic [31:0] stack_init_q, pc_q, pend_q;
  phase_e      phase_q;
  logic        halt_q, can_push, acc;
  logic [31:0] rf_q [32];
  logic [4:0]  rs1, rs2;
  step_t       step;
  cmd_t        cmd;

  assign cmd      = in_i.data;
  assign in_i.ready = can_push;
  assign acc      = in_i.valid && can_push;

  rcs_exec u_exec (
    .cmd_i(cmd), .stack_init_i(stack_init_q), .pc_i(pc_q), .phase_i(phase_q),
    .pend_i(pend_q), .halt_i(halt_q), .rs1_val_i(rs1 == 5'd0 ? 32'd0 : rf_q[rs1]),
    .rs2_val_i(rs2 == 5'd0 ? 32'd0 : rf_q[rs2]), .a0_val_i(rf_q[RegA0]),
    .a1_val_i(rf_q[RegA1]), .rs1_o(rs1), .rs2_o(rs2), .step_o(step)
  );

  rcs_out_queue u_q (
    .clk_i, .rst_ni, .push_i(acc && step.any_res), .two_i(step.n_res),
    .res0_i(step.res0), .res1_i(step.res1), .can_push_o(can_push), .out_o
  );

  // Hold architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_init_q <= MemBytes[31:0];
      pc_q    <= '0;
      pend_q  <= '0;
      phase_q <= PH_FETCH;
      halt_q  <= 1'b0;
    end else begin
      if (cfg_we_i) stack_init_q <= cfg_wdata_i;
      if (acc) begin
        pc_q    <= step.pc_next;
        pend_q  <= step.pend_next;
        phase_q <= step.phase_next;
        halt_q  <= step.halt_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && step.rf_we) rf_q[step.rf_waddr] <= step.rf_wdata;
  end

  `RCS_ASSERT_NEVER(a_halt_not_wait, clk_i, rst_ni, halt_q && phase_q != PH_FETCH)
  `RCS_ASSERT_IMP(a_two_not_exc, clk_i, rst_ni, acc && step.n_res,
                  !step.res0.exception_valid && step.res0.write_enable)
  `RCS_ASSERT_IMP(a_exc_halts, clk_i, rst_ni, acc && step.res0.exception_valid && cmd.cmd,
                  step.halt_next)

endmodule

/* test/testbench.sv */
module testbench;
  import rcs_pkg::*;

  // Funct3 and funct7 codes used by the predictor and the instruction builder
  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_B = 3'd0, F3_H = 3'd1, F3_W = 3'd2, F3_BU = 3'd4, F3_HU = 3'd5;
  localparam logic [6:0] F7_ALT = 7'h20;
  localparam int PhaseItems = 325;
  localparam int HoldCycles = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  rcs_stream_if #(.Width($bits(cmd_t))) cmd_if ();
  rcs_stream_if #(.Width($bits(result_t))) res_if ();

  rv32i_core_mem_sequencer dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i(cmd_if),
    .out_o(res_if)
  );

  // Core state mirror
  logic [31:0] core_pc;
  logic [31:0] core_regs [32];
  bit          reg_written [32];
  phase_e      core_phase;
  logic [31:0] wait_instr;
  logic        core_halted;
  logic [31:0] stack_val;

  result_t req_q [$];
  int errors, n_items, n_results, n_traps, n_ecalls, n_mem;
  bit ignored;
  int burst_left;
  bit sender_gaps;
  int rx_mode;
  int hold_reqs, hold_seen, hold_left;
  int rx_cnt;

  typedef struct {
    cmd_t    item;
    bit      typed;
    result_t res;
  } dir_row_t;
  dir_row_t dir_rows [$];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic result_t mem_req(input logic [31:0] baddr, input logic we,
                                      input logic [31:0] wd, input logic last);
    result_t r;
    r = '0;
    r.mem_word_addr = baddr[15:2];
    r.write_enable = we;
    r.write_data = wd;
    r.is_last = last;
    return r;
  endfunction

  function automatic result_t trap_res(input exc_e code);
    result_t r;
    r = '0;
    r.exception_valid = 1'b1;
    r.exception_code = code;
    r.is_last = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] imm_i(input logic [31:0] w);
    return {{20{w[31]}}, w[31:20]};
  endfunction

  function automatic logic [31:0] imm_s(input logic [31:0] w);
    return {{20{w[31]}}, w[31:25], w[11:7]};
  endfunction

  function automatic logic [31:0] imm_b(input logic [31:0] w);
    return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

  function automatic logic [31:0] imm_j(input logic [31:0] w);
    return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  endfunction

  function automatic logic [31:0] alu_out(input logic [2:0] f3, input logic alt,
                                          input logic [31:0] a, input logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << sh;
      F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? $unsigned($signed(a) >>> sh) : a >> sh;
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // Address of a load or store from the current register values
  function automatic logic [31:0] eff_addr(input logic [31:0] w);
    return core_regs[w[19:15]] + ((w[6:0] == OP_STORE) ? imm_s(w) : imm_i(w));
  endfunction

  task automatic set_reg(input logic [4:0] rd, input logic [31:0] v);
    if (rd != 5'd0) begin
      core_regs[rd] = v;
      reg_written[rd] = 1'b1;
    end
  endtask

  task automatic trap(input exc_e code);
    core_halted = 1'b1;
    core_phase = PH_FETCH;
    req_q.push_back(trap_res(code));
    n_traps++;
  endtask

  // Decode and execute one fetched word
  task automatic exec_word(input logic [31:0] w);
    logic [6:0] op, f7;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [31:0] a, b, nxt, addr;
    logic cond, ecv;
    result_t r;
    op = w[6:0];
    rd = w[11:7];
    f3 = w[14:12];
    f7 = w[31:25];
    a = core_regs[w[19:15]];
    b = core_regs[w[24:20]];
    nxt = core_pc + 32'd4;
    ecv = 1'b0;
    cond = 1'b0;
    case (op)
      OP_LUI: set_reg(rd, {w[31:12], 12'b0});
      OP_AUIPC: set_reg(rd, core_pc + {w[31:12], 12'b0});
      OP_JAL: begin
        set_reg(rd, nxt);
        nxt = core_pc + imm_j(w);
      end
      OP_JALR: begin
        if (f3 != 3'd0) begin
          trap(EXC_ILLEGAL);
          return;
        end
        addr = (a + imm_i(w)) & ~32'd1;
        set_reg(rd, nxt);
        nxt = addr;
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  cond = a == b;
          F3_BNE:  cond = a != b;
          F3_BLT:  cond = $signed(a) < $signed(b);
          F3_BGE:  cond = $signed(a) >= $signed(b);
          F3_BLTU: cond = a < b;
          F3_BGEU: cond = a >= b;
          default: begin
            trap(EXC_ILLEGAL);
            return;
          end
        endcase
        if (cond) nxt = core_pc + imm_b(w);
      end
      OP_LOAD: begin
        if (!(f3 inside {F3_B, F3_H, F3_W, F3_BU, F3_HU})) begin
          trap(EXC_ILLEGAL);
          return;
        end
        addr = eff_addr(w);
        if ((f3 == F3_W && addr[1:0] != 2'd0) || ((f3 == F3_H || f3 == F3_HU) && addr[0])) begin
          trap(EXC_MISALIGN);
          return;
        end
        wait_instr = w;
        core_phase = PH_LOAD;
        req_q.push_back(mem_req(addr, 1'b0, 32'd0, 1'b1));
        n_mem++;
        return;
      end
      OP_STORE: begin
        if (f3 > F3_W) begin
          trap(EXC_ILLEGAL);
          return;
        end
        addr = eff_addr(w);
        if ((f3 == F3_W && addr[1:0] != 2'd0) || (f3 == F3_H && addr[0])) begin
          trap(EXC_MISALIGN);
          return;
        end
        n_mem++;
        if (f3 == F3_W) begin
          core_pc = nxt;
          req_q.push_back(mem_req(addr, 1'b1, b, 1'b0));
          req_q.push_back(mem_req(nxt, 1'b0, 32'd0, 1'b1));
          return;
        end
        wait_instr = w;
        core_phase = PH_STORE;
        req_q.push_back(mem_req(addr, 1'b0, 32'd0, 1'b1));
        return;
      end
      OP_IMM: begin
        if ((f3 == F3_SLL && f7 != 7'd0) ||
            (f3 == F3_SR && f7 != 7'd0 && f7 != F7_ALT)) begin
          trap(EXC_ILLEGAL);
          return;
        end
        set_reg(rd, alu_out(f3, f3 == F3_SR && f7 == F7_ALT, a, imm_i(w)));
      end
      OP_REG: begin
        if (f7 != 7'd0 && !(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
          trap(EXC_ILLEGAL);
          return;
        end
        set_reg(rd, alu_out(f3, f7 == F7_ALT, a, b));
      end
      OP_FENCE: begin
        if (f3 != 3'd0) begin
          trap(EXC_ILLEGAL);
          return;
        end
      end
      OP_SYSTEM: begin
        if (w == InstrEbreak) begin
          trap(EXC_BREAK);
          return;
        end
        if (w != InstrEcall) begin
          trap(EXC_ILLEGAL);
          return;
        end
        ecv = 1'b1;
      end
      default: begin
        trap(EXC_ILLEGAL);
        return;
      end
    endcase
    core_pc = nxt;
    if (nxt[1:0] != 2'd0) begin
      trap(EXC_MISALIGN);
      return;
    end
    r = mem_req(nxt, 1'b0, 32'd0, 1'b1);
    if (ecv) begin
      r.ecall_valid = 1'b1;
      r.ecall_arg0 = core_regs[RegA0];
      r.ecall_arg1 = core_regs[RegA1];
      n_ecalls++;
    end
    req_q.push_back(r);
  endtask

  // Advance the mirror by one accepted transfer and queue its requests
  task automatic predict(input cmd_t c);
    logic [31:0] w, addr, v, m, d;
    logic [4:0] off;
    logic [2:0] f3;
    ignored = 1'b0;
    if (!c.cmd) begin
      core_pc = 32'd0;
      set_reg(RegSp, stack_val);
      core_phase = PH_FETCH;
      wait_instr = 32'd0;
      core_halted = 1'b0;
      req_q.push_back(mem_req(32'd0, 1'b0, 32'd0, 1'b1));
      return;
    end
    if (core_halted) begin
      ignored = 1'b1;
      return;
    end
    w = wait_instr;
    f3 = w[14:12];
    addr = eff_addr(w);
    d = c.read_data;
    if (core_phase == PH_LOAD) begin
      case (f3)
        F3_B:    v = {{24{d[addr[1:0]*8+7]}}, d[addr[1:0]*8 +: 8]};
        F3_H:    v = {{16{d[addr[1]*16+15]}}, d[addr[1]*16 +: 16]};
        F3_BU:   v = {24'd0, d[addr[1:0]*8 +: 8]};
        F3_HU:   v = {16'd0, d[addr[1]*16 +: 16]};
        default: v = d;
      endcase
      set_reg(w[11:7], v);
      core_pc = core_pc + 32'd4;
      core_phase = PH_FETCH;
      req_q.push_back(mem_req(core_pc, 1'b0, 32'd0, 1'b1));
    end else if (core_phase == PH_STORE) begin
      v = core_regs[w[24:20]];
      if (f3 == F3_B) begin
        off = {addr[1:0], 3'b000};
        m = 32'hFF;
      end else begin
        off = {addr[1], 4'b0000};
        m = 32'hFFFF;
      end
      d = (d & ~(m << off)) | ((v & m) << off);
      core_pc = core_pc + 32'd4;
      core_phase = PH_FETCH;
      req_q.push_back(mem_req(addr, 1'b1, d, 1'b0));
      req_q.push_back(mem_req(core_pc, 1'b0, 32'd0, 1'b1));
    end else begin
      exec_word(d);
    end
  endtask

  function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
                                        input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [12:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  function automatic logic [4:0] pick_reg();
    logic [4:0] r;
    r = 5'($urandom_range(0, 31));
    return reg_written[r] ? r : 5'd0;
  endfunction

  // Keep every register read pointed at a register that holds a value
  function automatic logic [31:0] fix_regs(input logic [31:0] w);
    logic [6:0] op;
    op = w[6:0];
    if (op inside {OP_JALR, OP_BRANCH, OP_LOAD, OP_STORE, OP_IMM, OP_REG} &&
        !reg_written[w[19:15]]) w[19:15] = 5'd0;
    if (op inside {OP_BRANCH, OP_STORE, OP_REG} && !reg_written[w[24:20]]) w[24:20] = 5'd0;
    if (w == InstrEcall && !(reg_written[RegA0] && reg_written[RegA1]))
      w = {25'd0, OP_FENCE};
    return w;
  endfunction

  function automatic logic [31:0] gen_instr();
    int kind;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [31:0] w;
    logic [12:0] boff;
    logic [20:0] joff;
    logic [11:0] moff;
    kind = $urandom_range(0, 99);
    rd = 5'($urandom_range(0, 31));
    rs1 = pick_reg();
    rs2 = pick_reg();
    f3 = 3'($urandom_range(0, 7));
    w = $urandom();
    moff = ($urandom_range(0, 1) != 0) ? 12'($urandom()) : 12'($urandom_range(0, 63));
    if ($urandom_range(0, 1) != 0) rs1 = 5'd0;
    if (kind < 10) begin
      w = {w[31:12], rd, OP_LUI};
    end else if (kind < 14) begin
      w = {w[31:12], rd, OP_AUIPC};
    end else if (kind < 18) begin
      joff = 21'(($urandom_range(0, 63) - 32) * 4);
      if ($urandom_range(0, 7) == 0) joff[1] = 1'b1;
      w = enc_j(rd, joff);
    end else if (kind < 21) begin
      w = enc_i(OP_JALR, rd, ($urandom_range(0, 9) == 0) ? f3 : 3'd0, rs1,
                12'($urandom_range(0, 31) * 4 + $urandom_range(0, 1)));
    end else if (kind < 33) begin
      boff = 13'(($urandom_range(0, 15) - 8) * 4);
      if ($urandom_range(0, 9) == 0) boff[1] = 1'b1;
      w = enc_b(f3, rs1, rs2, boff);
    end else if (kind < 48) begin
      if ($urandom_range(0, 9) != 0) f3 = ($urandom_range(0, 1) != 0) ? F3_W : 3'(f3 & 3'd5);
      w = enc_i(OP_LOAD, rd, f3, rs1, moff);
    end else if (kind < 60) begin
      if ($urandom_range(0, 9) != 0) f3 = 3'($urandom_range(0, 2));
      w = enc_s(f3, rs1, rs2, moff);
    end else if (kind < 78) begin
      f7 = ($urandom_range(0, 1) != 0) ? F7_ALT : 7'd0;
      if ($urandom_range(0, 19) == 0) f7 = 7'($urandom());
      if (f3 == F3_SLL || f3 == F3_SR) w = enc_i(OP_IMM, rd, f3, rs1, {f7, w[24:20]});
      else w = enc_i(OP_IMM, rd, f3, rs1, w[31:20]);
    end else if (kind < 92) begin
      f7 = (f3 == F3_ADD || f3 == F3_SR) && ($urandom_range(0, 1) != 0) ? F7_ALT : 7'd0;
      if ($urandom_range(0, 19) == 0) f7 = 7'($urandom());
      w = enc_r(f7, rs2, rs1, f3, rd);
    end else if (kind < 94) begin
      w = enc_i(OP_FENCE, rd, ($urandom_range(0, 3) == 0) ? f3 : 3'd0, rs1, w[31:20]);
    end else if (kind < 97) begin
      w = InstrEcall;
    end else if (kind < 98) begin
      w = InstrEbreak;
    end
    return fix_regs(w);
  endfunction

  function automatic cmd_t next_item();
    cmd_t c;
    c.cmd = 1'b1;
    c.read_data = $urandom();
    if (core_halted) begin
      if ($urandom_range(0, 9) < 8) c.cmd = 1'b0;
      return c;
    end
    if ($urandom_range(0, 49) == 0) c.cmd = 1'b0;
    if (core_phase == PH_FETCH) c.read_data = gen_instr();
    return c;
  endfunction

  // Offer one transfer, wait for it to be taken, then maybe open a gap
  task automatic send(input cmd_t c);
    int gap;
    cmd_if.valid <= 1'b1;
    cmd_if.data <= c;
    do @(posedge clk_i); while (!cmd_if.ready);
    predict(c);
    n_items++;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Drop valid right after the last transfer, then wait for every result
  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (req_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_stack(input logic [31:0] v);
    drain();
    repeat (5) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    stack_val = v;
  endtask

  // Receiver: long hold on request, else ready follows the current pattern
  always @(posedge clk_i) begin
    rx_cnt <= rx_cnt + 1;
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= ($urandom_range(0, 3) != 0);
        default: res_if.ready <= (rx_cnt % 7) > 2;
      endcase
    end
  end

  task automatic chk(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // Compare each taken result with the oldest expected request
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = result_t'(res_if.data);
      n_results++;
      if (req_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
      end else begin
        want = req_q.pop_front();
        chk("mem_word_addr", 32'(want.mem_word_addr), 32'(got.mem_word_addr));
        chk("write_enable", 32'(want.write_enable), 32'(got.write_enable));
        chk("write_data", want.write_data, got.write_data);
        chk("exception_valid", 32'(want.exception_valid), 32'(got.exception_valid));
        chk("exception_code", 32'(want.exception_code), 32'(got.exception_code));
        chk("ecall_valid", 32'(want.ecall_valid), 32'(got.ecall_valid));
        chk("ecall_arg0", want.ecall_arg0, got.ecall_arg0);
        chk("ecall_arg1", want.ecall_arg1, got.ecall_arg1);
        chk("is_last", 32'(want.is_last), 32'(got.is_last));
      end
    end
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic dir_row_t row(input logic cmd, input logic [31:0] data,
                                   input bit typed, input result_t res);
    dir_row_t r;
    r.item.cmd = cmd;
    r.item.read_data = data;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  initial begin
    logic [31:0] stack_vals [4];
    cmd_t c;
    int cnt, waited;
    result_t none;
    none = '0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 32'd0;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    res_if.ready = 1'b0;
    rx_cnt = 0;
    rx_mode = 0;
    hold_reqs = 0;
    hold_seen = 0;
    hold_left = 0;
    burst_left = 0;
    sender_gaps = 1'b0;
    core_pc = 32'd0;
    core_phase = PH_FETCH;
    wait_instr = 32'd0;
    core_halted = 1'b0;
    stack_val = MemBytesDefault[31:0];
    for (int i = 0; i < 32; i++) begin
      core_regs[i] = 32'd0;
      reg_written[i] = (i == 0);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset fetch, ALU extremes, ecall, stores, loads, every trap
    dir_rows.push_back(row(1, enc_i(OP_IMM, 5'd1, F3_ADD, 5'd0, 12'd5), 0, none));
    dir_rows.push_back(row(0, 32'd0, 1, mem_req(32'd0, 0, 32'd0, 1)));
    dir_rows.push_back(row(1, {20'hFFFFF, 5'd10, OP_LUI}, 0, none));
    dir_rows.push_back(row(1, enc_i(OP_IMM, 5'd11, F3_ADD, 5'd0, 12'hFFF), 0, none));
    dir_rows.push_back(row(1, enc_r(7'd0, 5'd11, 5'd10, F3_ADD, 5'd3), 0, none));
    dir_rows.push_back(row(1, enc_r(F7_ALT, 5'd11, 5'd0, F3_ADD, 5'd4), 0, none));
    dir_rows.push_back(row(1, enc_r(F7_ALT, 5'd11, 5'd10, F3_SR, 5'd5), 0, none));
    dir_rows.push_back(row(1, enc_r(7'd0, 5'd11, 5'd10, F3_SLTU, 5'd6), 0, none));
    dir_rows.push_back(row(1, enc_i(OP_IMM, 5'd7, F3_SLL, 5'd11, {7'd0, 5'd31}), 0, none));
    dir_rows.push_back(row(1, enc_i(OP_IMM, 5'd8, F3_SR, 5'd10, {F7_ALT, 5'd4}), 0, none));
    dir_rows.push_back(row(1, InstrEcall, 0, none));
    dir_rows.push_back(row(1, enc_s(F3_W, 5'd2, 5'd11, 12'd0), 0, none));
    dir_rows.push_back(row(1, enc_s(F3_B, 5'd0, 5'd10, 12'd1), 0, none));
    dir_rows.push_back(row(1, 32'hFFFF_FFFF, 0, none));
    dir_rows.push_back(row(1, enc_i(OP_LOAD, 5'd9, F3_H, 5'd0, 12'd2), 0, none));
    dir_rows.push_back(row(1, 32'h8000_1234, 0, none));
    dir_rows.push_back(row(1, enc_i(OP_LOAD, 5'd12, F3_W, 5'd0, 12'd1), 1,
                           trap_res(EXC_MISALIGN)));
    dir_rows.push_back(row(1, 32'd0, 0, none));
    dir_rows.push_back(row(0, 32'd0, 1, mem_req(32'd0, 0, 32'd0, 1)));
    dir_rows.push_back(row(1, 32'hFFFF_FFFF, 1, trap_res(EXC_ILLEGAL)));
    dir_rows.push_back(row(0, 32'd0, 1, mem_req(32'd0, 0, 32'd0, 1)));
    dir_rows.push_back(row(1, InstrEbreak, 1, trap_res(EXC_BREAK)));
    dir_rows.push_back(row(0, 32'd0, 1, mem_req(32'd0, 0, 32'd0, 1)));
    dir_rows.push_back(row(1, enc_j(5'd1, 21'd2), 1, trap_res(EXC_MISALIGN)));
    dir_rows.push_back(row(0, 32'd0, 0, none));
    dir_rows.push_back(row(1, {20'h80000, 5'd13, OP_AUIPC}, 0, none));
    dir_rows.push_back(row(1, {25'd0, OP_FENCE}, 0, none));
    dir_rows.push_back(row(1, enc_b(F3_BEQ, 5'd0, 5'd0, 13'h1FFC), 0, none));

    write_stack(MemBytesDefault[31:0]);
    foreach (dir_rows[i]) begin
      send(dir_rows[i].item);
      if (dir_rows[i].typed) req_q[req_q.size() - 1] = dir_rows[i].res;
    end

    // Random programs under several stack settings and flow patterns
    stack_vals[0] = 32'd0;
    stack_vals[1] = 32'hFFFF_FFFF;
    stack_vals[2] = $urandom();
    stack_vals[3] = MemBytesDefault[31:0];
    for (int ph = 0; ph < 4; ph++) begin
      write_stack(stack_vals[ph]);
      rx_mode = ph % 3;
      sender_gaps = (ph != 0);
      cnt = 0;
      while (cnt < PhaseItems) begin
        if (ph == 1 && cnt == 100) hold_reqs++;
        if (ph == 2 && cnt == 150) drain();
        c = next_item();
        send(c);
        if (!ignored) cnt++;
      end
    end

    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (req_q.size() != 0) begin
      @(posedge clk_i);
      waited++;
      if (waited > 100000) begin
        $display("FAILURE");
        $finish;
      end
    end
    repeat (20) @(posedge clk_i);
    $display("Ran %0d transfers, %0d results: %0d traps, %0d ecalls, %0d memory ops.",
             n_items, n_results, n_traps, n_ecalls, n_mem);
    $display("Stack settings 0, all ones, random and default; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
